[design/lrfe_pkg.sv]
// -----------------------------------------------------------------------------
// lrfe_pkg
// Types and codes shared by the linear ramp fade engine.
// -----------------------------------------------------------------------------
package lrfe_pkg;

  // Fixed port widths
  localparam int unsigned DUR_W       = 32;  // duration register
  localparam int unsigned TIME_IN_W   = 32;  // time_amount field
  localparam int unsigned CFG_DATA_W  = 32;  // widest register
  localparam int unsigned CFG_INDEX_W = 3;

  // Channel slots on the ports
  localparam int unsigned MAX_CH = 3;
  localparam int unsigned CH_W   = 2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DURATION  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOP_MODE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BEGIN_0   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BEGIN_1   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BEGIN_2   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_END_0     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_END_1     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_END_2     = 3'd7;

  // Loop mode codes
  localparam logic [1:0] LOOP_FINITE    = 2'd0;
  localparam logic [1:0] LOOP_RESTART   = 2'd1;
  localparam logic [1:0] LOOP_PING_PONG = 2'd2;

  // Request time mode codes
  localparam logic TIME_ADD = 1'b0;
  localparam logic TIME_SET = 1'b1;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_ACC  = 5'b01000,
    S_OUT  = 5'b10000
  } lrfe_state_t;

endpackage

[design/linear_ramp_fade_engine_unit.sv]
// -----------------------------------------------------------------------------
// linear_ramp_fade_engine_unit
// Three-channel linear ramp (fade) engine with finite, restart and ping-pong
// end-of-ramp behaviour.
// -----------------------------------------------------------------------------
// Usage:
//  - Configuration: cfg_write_en/cfg_index/cfg_data write one register per
//    clock (0 duration, 1 loop mode, 2..4 begin values, 5..7 end values).
//    Write only while the engine is idle with no request outstanding.
//  - Input request (in_valid/in_ready): mode 0 adds time_amount to elapsed
//    time (saturating), mode 1 sets it. in_ready is high only while idle.
//  - Result (out_valid/out_ready): three channel values plus endlife,
//    finished and reversed flags, held in an output register.
//  - Sequence: the restoring divider forms FRACTION_BITS progress bits, one
//    quotient bit a cycle, then the single shared multiplier serves each
//    channel in turn (multiply, then accumulate); the divider is skipped at
//    end of ramp. The result is loaded in the final state, and in_ready
//    returns as it is loaded, so a new request is accepted only after the
//    last one has left the sequencer.
//  - A stalled receiver holds the result register; the next request may be
//    accepted and worked on, and waits in the final state until the register
//    frees up.
//  - Reset (rst, synchronous) restores duration 1, finite mode, zero values,
//    zero elapsed time, forward direction and clears finished.
// -----------------------------------------------------------------------------
module linear_ramp_fade_engine_unit #(
  parameter int unsigned CHANNELS      = 3,
  parameter int unsigned VALUE_WIDTH   = 16,
  parameter int unsigned TIME_WIDTH    = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                cfg_write_en,
  input  logic [lrfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lrfe_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input requests
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [lrfe_pkg::TIME_IN_W-1:0]      time_amount,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [VALUE_WIDTH-1:0]       value_0,
  output logic signed [VALUE_WIDTH-1:0]       value_1,
  output logic signed [VALUE_WIDTH-1:0]       value_2,
  output logic                                endlife_pulse,
  output logic                                finished_flag,
  output logic                                reversed_flag
);

  import lrfe_pkg::*;

  // Derived widths
  localparam int unsigned VW    = VALUE_WIDTH;
  localparam int unsigned TW    = TIME_WIDTH;
  localparam int unsigned FB    = FRACTION_BITS;
  localparam int unsigned AW    = (TW > TIME_IN_W) ? TW : TIME_IN_W;  // amount staging
  localparam int unsigned CW    = (TW > DUR_W) ? TW : DUR_W;          // end-of-ramp compare
  localparam int unsigned PW    = VW + FB + 3;                        // product width
  localparam int unsigned CNT_W = $clog2(FB);
  localparam logic [FB:0] ONE_Q = {1'b1, {FB{1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DUR_W-1:0]       duration;
  logic [1:0]             loop_mode;
  logic signed [VW-1:0]   begin_val [MAX_CH];
  logic signed [VW-1:0]   end_val   [MAX_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      duration  <= DUR_W'(1);
      loop_mode <= LOOP_FINITE;
      for (int i = 0; i < MAX_CH; i++) begin
        begin_val[i] <= '0;
        end_val[i]   <= '0;
      end
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_DURATION:  duration     <= cfg_data[DUR_W-1:0];
        REG_LOOP_MODE: loop_mode    <= cfg_data[1:0];
        REG_BEGIN_0:   begin_val[0] <= cfg_data[VW-1:0];
        REG_BEGIN_1:   begin_val[1] <= cfg_data[VW-1:0];
        REG_BEGIN_2:   begin_val[2] <= cfg_data[VW-1:0];
        REG_END_0:     end_val[0]   <= cfg_data[VW-1:0];
        REG_END_1:     end_val[1]   <= cfg_data[VW-1:0];
        REG_END_2:     end_val[2]   <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Ramp state and sequencer registers
  // ---------------------------------------------------------------------------
  lrfe_state_t          state;
  logic [TW-1:0]        elapsed;
  logic                 reverse_dir;
  logic                 done_flag;
  logic                 at_end_r;    // this request reached end of ramp
  logic                 rev_used;    // direction the values are computed in
  logic [DUR_W-1:0]     rem;         // divider remainder
  logic [FB-1:0]        quot;        // progress bits, MSB first
  logic [CNT_W-1:0]     div_cnt;
  logic [CH_W-1:0]      ch;
  logic signed [PW-1:0] prod;
  logic signed [VW-1:0] val_res [MAX_CH];

  logic signed [VW-1:0] val_out [MAX_CH];

  logic                 accept;
  logic                 out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // ---------------------------------------------------------------------------
  // Elapsed time update, evaluated on the accepted request
  // ---------------------------------------------------------------------------
  logic [AW-1:0] amt_wide;
  logic [TW-1:0] amt;
  logic [TW:0]   sum;
  logic [TW-1:0] new_el;
  logic          at_end_c;

  always_comb begin
    amt_wide = AW'(time_amount);
    amt      = amt_wide[TW-1:0];
    sum      = {1'b0, elapsed} + {1'b0, amt};
    if (mode == TIME_SET) begin
      new_el = amt;
    end else if (sum[TW]) begin
      new_el = '1;  // saturate
    end else begin
      new_el = sum[TW-1:0];
    end
    at_end_c = CW'(new_el) >= CW'(duration);
  end

  // ---------------------------------------------------------------------------
  // Shared datapath: divider step, multiply, accumulate
  // ---------------------------------------------------------------------------
  logic [DUR_W:0]       rem_sh;
  logic                 rem_ge;
  logic [FB:0]          prog_c;
  logic [FB:0]          eff_c;
  logic signed [VW:0]   diff_c;
  logic signed [PW-1:0] prod_c;
  logic signed [PW-1:0] acc_c;

  always_comb begin
    rem_sh = {rem, 1'b0};
    rem_ge = rem_sh >= {1'b0, duration};

    prog_c = at_end_r ? ONE_Q : {1'b0, quot};
    eff_c  = rev_used ? (ONE_Q - prog_c) : prog_c;

    diff_c = (VW+1)'(end_val[ch]) - (VW+1)'(begin_val[ch]);
    prod_c = PW'(diff_c) * PW'($signed({1'b0, eff_c}));

    // floor division by 2^FB is an arithmetic shift
    acc_c  = PW'(begin_val[ch]) + (prod >>> FB);
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      elapsed     <= '0;
      reverse_dir <= 1'b0;
      done_flag   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // result register fills as the request leaves, empties on acceptance
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            at_end_r <= at_end_c;
            rev_used <= reverse_dir;
            rem      <= DUR_W'(new_el);  // fits whenever the divider runs
            div_cnt  <= '0;
            ch       <= '0;
            if (at_end_c && (loop_mode == LOOP_RESTART || loop_mode == LOOP_PING_PONG)) begin
              elapsed <= '0;
            end else begin
              elapsed <= new_el;
            end
            if (at_end_c && loop_mode == LOOP_FINITE) begin
              done_flag <= 1'b1;
            end
            if (at_end_c && loop_mode == LOOP_PING_PONG) begin
              reverse_dir <= !reverse_dir;
            end
            state <= at_end_c ? S_MUL : S_DIV;
          end
        end

        S_DIV: begin
          quot <= {quot[FB-2:0], rem_ge};
          if (rem_ge) begin
            rem <= DUR_W'(rem_sh - {1'b0, duration});
          end else begin
            rem <= rem_sh[DUR_W-1:0];
          end
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(FB - 1)) begin
            state <= S_MUL;
          end
        end

        S_MUL: begin
          prod  <= prod_c;
          state <= S_ACC;
        end

        S_ACC: begin
          if (at_end_r && loop_mode == LOOP_RESTART) begin
            val_res[ch] <= begin_val[ch];
          end else begin
            val_res[ch] <= acc_c[VW-1:0];
          end
          if (ch == CH_W'(CHANNELS - 1)) begin
            state <= S_OUT;
          end else begin
            ch    <= ch + CH_W'(1);
            state <= S_MUL;
          end
        end

        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register, loaded as the request leaves the sequencer
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      for (int i = 0; i < MAX_CH; i++) begin
        val_out[i] <= val_res[i];
      end
      endlife_pulse <= at_end_r;
      finished_flag <= done_flag;
      reversed_flag <= reverse_dir;
    end
  end

  // Unused channel slots read as zero
  assign value_0 = val_out[0];
  assign value_1 = (CHANNELS > 1) ? val_out[1] : '0;
  assign value_2 = (CHANNELS > 2) ? val_out[2] : '0;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("in_ready high the cycle after a request was accepted");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done_flag |=> done_flag)
    else $error("finished state cleared without reset");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt <= CNT_W'(FB - 1)))
    else $error("divider ran past the last fraction bit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !out_ready) |=> (state == S_OUT))
    else $error("result left the sequencer while the output register was full");

endmodule
